// ----- design/serial_hex_command_decoder_core_assert.svh -----
// Assertion macros for the serial hex command decoder
`ifndef SERIAL_HEX_COMMAND_DECODER_CORE_ASSERT_SVH
`define SERIAL_HEX_COMMAND_DECODER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SHCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shcd assertion failed");

// Check that cons holds in the cycle after ante
`define SHCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shcd assertion failed");

`endif

// ----- design/shcd_pkg.sv -----
// Shared types, constants and tables of the serial hex command decoder
package shcd_pkg;

  // Command letters
  localparam logic [7:0] CmdPort    = 8'h42; // 'B'
  localparam logic [7:0] CmdDigit   = 8'h44; // 'D'
  localparam logic [7:0] CmdSegClr  = 8'h53; // 'S'
  localparam logic [7:0] CmdSegSet  = 8'h48; // 'H'
  localparam logic [7:0] CmdPeriod  = 8'h50; // 'P'
  localparam logic [7:0] CmdNote    = 8'h4F; // 'O'
  localparam logic [7:0] CmdMelody  = 8'h4D; // 'M'
  localparam logic [7:0] MelodyOn   = 8'h31; // '1'

  // Reply characters
  localparam logic [7:0] ReplyDot   = 8'h2E; // '.'
  localparam logic [7:0] ReplyBang  = 8'h21; // '!'
  localparam logic [7:0] ReplyBar   = 8'h7C; // '|'
  localparam logic [7:0] ReplyQuery = 8'h3F; // '?'

  // Tone base register
  localparam int unsigned BaseW     = 24;
  localparam logic [BaseW-1:0] BaseReset = 24'd1000000;
  localparam int unsigned FreqW     = 12;

  // Serial divider: one quotient bit per step
  localparam int unsigned DivSteps  = BaseW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  // Request to the divider
  typedef struct packed {
    logic             start;
    logic [BaseW-1:0] dividend;
    logic [FreqW-1:0] divisor;
  } shcd_div_req_t;

  // Status of the divider
  typedef struct packed {
    logic             busy;
    logic [BaseW-1:0] quotient;
  } shcd_div_rsp_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  reply;
    logic        port_write;
    logic [7:0]  port_value;
    logic        display_write;
    logic [7:0]  display_bits;
    logic        tone_write;
    logic        tone_enable;
    logic [15:0] tone_top;
    logic [14:0] tone_compare;
    logic        melody_request;
  } shcd_res_t;

  // Hex digit value; non-hex bytes count as zero
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b >= 8'h41 && b <= 8'h46) v = b - 8'h37;       // 'A' - 10
    else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;  // 'a' - 10
    else if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
    return v[3:0];
  endfunction

  // Seven-segment pattern of a hex digit
  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'h0: p = 8'hBE;
      4'h1: p = 8'hA0;
      4'h2: p = 8'h3B;
      4'h3: p = 8'hB9;
      4'h4: p = 8'hA5;
      4'h5: p = 8'h9D;
      4'h6: p = 8'h9F;
      4'h7: p = 8'hB0;
      4'h8: p = 8'hBF;
      4'h9: p = 8'hBD;
      4'hA: p = 8'hB7;
      4'hB: p = 8'h8F;
      4'hC: p = 8'h0B;
      4'hD: p = 8'hAB;
      4'hE: p = 8'h1F;
      4'hF: p = 8'h17;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Note frequency; index zero and indexes above nine give silence
  function automatic logic [FreqW-1:0] note_freq(input logic [3:0] n);
    logic [FreqW-1:0] f;
    unique case (n)
      4'd1: f = 12'd262;
      4'd2: f = 12'd294;
      4'd3: f = 12'd330;
      4'd4: f = 12'd349;
      4'd5: f = 12'd392;
      4'd6: f = 12'd440;
      4'd7: f = 12'd494;
      4'd8: f = 12'd523;
      4'd9: f = 12'd587;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

endpackage

// ----- design/shcd_if.sv -----
// Valid/ready stream interfaces for received bytes and result beats

interface shcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface shcd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply;
  logic        port_write;
  logic [7:0]  port_value;
  logic        display_write;
  logic [7:0]  display_bits;
  logic        tone_write;
  logic        tone_enable;
  logic [15:0] tone_top;
  logic [14:0] tone_compare;
  logic        melody_request;

  modport source (
    output valid, output reply, output port_write, output port_value,
    output display_write, output display_bits, output tone_write,
    output tone_enable, output tone_top, output tone_compare,
    output melody_request, input ready
  );
  modport sink (
    input valid, input reply, input port_write, input port_value,
    input display_write, input display_bits, input tone_write,
    input tone_enable, input tone_top, input tone_compare,
    input melody_request, output ready
  );
endinterface

// ----- design/shcd_cfg.sv -----
// APB register block holding the tone base
module shcd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [shcd_pkg::BaseW-1:0]  tone_base_o
);

  logic [shcd_pkg::BaseW-1:0] base_q, base_d;
  logic                       hit;

  // Decode the single register at word zero
  assign hit    = (paddr[2] == 1'b0);
  assign pready = 1'b1;

  // Write on the access phase
  always_comb begin
    base_d = base_q;
    if (psel && penable && pwrite && hit) begin
      base_d = pwdata[shcd_pkg::BaseW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= shcd_pkg::BaseReset;
    end else begin
      base_q <= base_d;
    end
  end

  // Read back
  assign prdata      = hit ? {{(32 - shcd_pkg::BaseW){1'b0}}, base_q} : 32'd0;
  assign tone_base_o = base_q;

endmodule

// ----- design/shcd_div.sv -----
// Serial restoring divider, one quotient bit per cycle
module shcd_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  shcd_pkg::shcd_div_req_t req_i,
  output shcd_pkg::shcd_div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic [shcd_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [shcd_pkg::BaseW-1:0]   quo_q, quo_d;
  logic [shcd_pkg::FreqW-1:0]   rem_q, rem_d;
  logic [shcd_pkg::FreqW-1:0]   dvs_q, dvs_d;
  logic [shcd_pkg::FreqW:0]     trial;
  logic [shcd_pkg::FreqW:0]     diff;
  logic                         fits;

  // Shift the next dividend bit into the partial remainder and try to subtract
  assign trial = {rem_q, quo_q[shcd_pkg::BaseW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = shcd_pkg::DivCntW'(shcd_pkg::DivSteps - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[shcd_pkg::BaseW-2:0], fits};
      rem_d = fits ? diff[shcd_pkg::FreqW-1:0] : trial[shcd_pkg::FreqW-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath needs no reset
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- design/serial_hex_command_decoder_core.sv -----
// Results: a result is registered in the cycle after its last byte; P and O with
// nonzero frequency first wait for the 24-step serial divider to finish.
// Throughput: one byte per cycle while the result register can take a beat;
// rx ready stays low during a tone division.
// Reset: asynchronous active low; command state idle, pattern zero,
// tone base back to 1000000, no result pending.
module serial_hex_command_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  shcd_rx_if.sink     rx_i,
  shcd_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "serial_hex_command_decoder_core_assert.svh"

  // Command phases
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhB    = 3'd1;
  localparam logic [2:0] PhD    = 3'd2;
  localparam logic [2:0] PhS    = 3'd3;
  localparam logic [2:0] PhH    = 3'd4;
  localparam logic [2:0] PhP    = 3'd5;
  localparam logic [2:0] PhO    = 3'd6;
  localparam logic [2:0] PhM    = 3'd7;

  // Sequencer states
  localparam logic CtlRun = 1'b0;
  localparam logic CtlDiv = 1'b1;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  digits_q, digits_d;
  logic [11:0] arg_q, arg_d;
  logic [7:0]  seg_q, seg_d;
  logic        ctl_q, ctl_d;
  logic        out_valid_q, out_valid_d;

  shcd_pkg::shcd_res_t     res_q, res_d;
  shcd_pkg::shcd_div_req_t div_req;
  shcd_pkg::shcd_div_rsp_t div_rsp;

  logic [shcd_pkg::BaseW-1:0] tone_base;
  logic                       accept;
  logic                       out_free;
  logic                       load_res;
  logic [3:0]                 hv;
  logic [11:0]                arg_cat;
  logic [1:0]                 dig_inc;
  logic [1:0]                 need;
  logic [11:0]                freq;
  logic [7:0]                 seg_mask;
  logic                       idx_ok;
  logic [shcd_pkg::BaseW-1:0] qm1;
  logic [15:0]                top;

  shcd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tone_base_o (tone_base)
  );

  shcd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Handshake
  assign out_free   = !out_valid_q || res_o.ready;
  assign rx_i.ready = (ctl_q == CtlRun) && out_free;
  assign accept     = rx_i.valid && rx_i.ready;

  // Argument digits
  assign hv      = shcd_pkg::hex_value(rx_i.rx_byte);
  assign arg_cat = {arg_q[7:0], hv};
  assign dig_inc = digits_q + 2'd1;
  assign need    = (phase_q == PhB) ? 2'd2 : (phase_q == PhP) ? 2'd3 : 2'd1;
  assign freq    = (phase_q == PhP) ? arg_cat : shcd_pkg::note_freq(hv);

  // Segment index n selects bit n-1; zero and above eight are no-ops
  assign idx_ok   = (hv != 4'd0) && (hv <= 4'd8);
  assign seg_mask = 8'd1 << (hv[2:0] - 3'd1);

  // Period top from the quotient, floored at zero and saturated
  assign qm1 = div_rsp.quotient - 1'b1;
  always_comb begin
    if (div_rsp.quotient == '0) begin
      top = 16'd0;
    end else if (|qm1[shcd_pkg::BaseW-1:16]) begin
      top = 16'hFFFF;
    end else begin
      top = qm1[15:0];
    end
  end

  // Sequence commands
  always_comb begin
    phase_d  = phase_q;
    digits_d = digits_q;
    arg_d    = arg_q;
    seg_d    = seg_q;
    ctl_d    = ctl_q;
    res_d    = '0;
    load_res = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = tone_base;
    div_req.divisor  = freq;

    if (ctl_q == CtlDiv) begin
      // Hand the tone beat over once the divider is through and the result register is free
      if (!div_rsp.busy && out_free) begin
        load_res           = 1'b1;
        res_d.reply        = shcd_pkg::ReplyBar;
        res_d.tone_write   = 1'b1;
        res_d.tone_enable  = 1'b1;
        res_d.tone_top     = top;
        res_d.tone_compare = top[15:1];
        ctl_d              = CtlRun;
      end
    end else if (accept) begin
      if (phase_q == PhIdle) begin
        digits_d = 2'd0;
        arg_d    = 12'd0;
        unique case (rx_i.rx_byte)
          shcd_pkg::CmdPort:   phase_d = PhB;
          shcd_pkg::CmdDigit:  phase_d = PhD;
          shcd_pkg::CmdSegClr: phase_d = PhS;
          shcd_pkg::CmdSegSet: phase_d = PhH;
          shcd_pkg::CmdPeriod: phase_d = PhP;
          shcd_pkg::CmdNote:   phase_d = PhO;
          shcd_pkg::CmdMelody: phase_d = PhM;
          default: begin
            load_res    = 1'b1;
            res_d.reply = shcd_pkg::ReplyQuery;
          end
        endcase
      end else if (phase_q == PhM) begin
        load_res             = 1'b1;
        res_d.reply          = shcd_pkg::ReplyBar;
        res_d.melody_request = (rx_i.rx_byte == shcd_pkg::MelodyOn);
        phase_d              = PhIdle;
        digits_d             = 2'd0;
        arg_d                = 12'd0;
      end else if (dig_inc < need) begin
        // Take a leading digit
        digits_d = dig_inc;
        arg_d    = arg_cat;
      end else begin
        // Last digit: finish the command
        phase_d  = PhIdle;
        digits_d = 2'd0;
        arg_d    = 12'd0;
        unique case (phase_q)
          PhB: begin
            load_res         = 1'b1;
            res_d.reply      = shcd_pkg::ReplyDot;
            res_d.port_write = 1'b1;
            res_d.port_value = arg_cat[7:0];
          end
          PhD: begin
            seg_d               = shcd_pkg::seg_pattern(hv);
            load_res            = 1'b1;
            res_d.reply         = shcd_pkg::ReplyBang;
            res_d.display_write = 1'b1;
            res_d.display_bits  = ~shcd_pkg::seg_pattern(hv);
          end
          PhS: begin
            seg_d               = idx_ok ? (seg_q & ~seg_mask) : seg_q;
            load_res            = 1'b1;
            res_d.reply         = shcd_pkg::ReplyBang;
            res_d.display_write = 1'b1;
            res_d.display_bits  = ~seg_d;
          end
          PhH: begin
            seg_d               = idx_ok ? (seg_q | seg_mask) : seg_q;
            load_res            = 1'b1;
            res_d.reply         = shcd_pkg::ReplyBar;
            res_d.display_write = 1'b1;
            res_d.display_bits  = ~seg_d;
          end
          default: begin
            // P and O: silence right away, otherwise divide
            if (freq == 12'd0) begin
              load_res         = 1'b1;
              res_d.reply      = shcd_pkg::ReplyBar;
              res_d.tone_write = 1'b1;
            end else begin
              div_req.start = 1'b1;
              ctl_d         = CtlDiv;
            end
          end
        endcase
      end
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      digits_q    <= 2'd0;
      arg_q       <= 12'd0;
      seg_q       <= 8'd0;
      ctl_q       <= CtlRun;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      digits_q    <= digits_d;
      arg_q       <= arg_d;
      seg_q       <= seg_d;
      ctl_q       <= ctl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload holds while not loaded
  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.reply          = res_q.reply;
  assign res_o.port_write     = res_q.port_write;
  assign res_o.port_value     = res_q.port_value;
  assign res_o.display_write  = res_q.display_write;
  assign res_o.display_bits   = res_q.display_bits;
  assign res_o.tone_write     = res_q.tone_write;
  assign res_o.tone_enable    = res_q.tone_enable;
  assign res_o.tone_top       = res_q.tone_top;
  assign res_o.tone_compare   = res_q.tone_compare;
  assign res_o.melody_request = res_q.melody_request;

  // No byte is taken while a division runs
  `SHCD_ASSERT_SAME(a_no_rx_in_div, ctl_q == CtlDiv, !rx_i.ready)
  // A new beat never overwrites one that is still waiting
  `SHCD_ASSERT_SAME(a_no_overwrite, load_res, !out_valid_q || res_o.ready)
  // A division starts only from the run state with the divider free, and leads to a busy divider in the divide state
  `SHCD_ASSERT_SAME(a_start_idle_div, div_req.start, !div_rsp.busy && ctl_q == CtlRun)
  `SHCD_ASSERT_NEXT(a_div_busy, div_req.start, div_rsp.busy && ctl_q == CtlDiv)
  // A running tone carries half duty
  `SHCD_ASSERT_SAME(a_half_duty, out_valid_q && res_o.tone_enable,
                    res_o.tone_compare == res_o.tone_top[15:1])

endmodule

// ----- tb/tb_serial_hex_command_decoder_core.sv -----
// Self-checking testbench for the serial hex command decoder: random byte streams, APB tone base
module tb_serial_hex_command_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam logic [2:0]  ADDR_TONE_BASE  = 3'd0;
  localparam logic [2:0]  ADDR_SPARE      = 3'd4;
  localparam logic [23:0] TONE_BASE_RST   = 24'd1000000;

  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_UP_A   = "A";
  localparam logic [7:0] CH_UP_F   = "F";
  localparam logic [7:0] CH_LO_A   = "a";
  localparam logic [7:0] CH_LO_F   = "f";
  localparam logic [7:0] CH_NONHEX = "z";
  localparam logic [7:0] CMD_LOWER = "b";

  // Segment patterns of the hex digits
  localparam logic [7:0] DIGIT_SEGS [16] = '{
    8'hBE, 8'hA0, 8'h3B, 8'hB9, 8'hA5, 8'h9D, 8'h9F, 8'hB0,
    8'hBF, 8'hBD, 8'hB7, 8'h8F, 8'h0B, 8'hAB, 8'h1F, 8'h17
  };

  typedef enum logic [2:0] {
    PH_IDLE, PH_PORT, PH_DIGIT, PH_SEG_CLR, PH_SEG_SET, PH_PERIOD, PH_NOTE, PH_MELODY
  } cmd_phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       hold;
  } rx_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  shcd_rx_if  rx_bus ();
  shcd_res_if res_bus ();

  serial_hex_command_decoder_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Decoder state as the testbench tracks it
  cmd_phase_e  cmd_phase = PH_IDLE;
  logic [1:0]  digit_cnt = '0;
  logic [11:0] arg_acc   = '0;
  logic [7:0]  seg_pat   = '0;
  logic [23:0] tone_base_q = TONE_BASE_RST;

  rx_item_t            byte_q[$];
  shcd_pkg::shcd_res_t command_results_q[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_gap   = 0;
  int unsigned rx_quiet = 0;
  int unsigned res_stall = 0;
  int unsigned res_quiet = 0;
  bit          rx_taken = 1'b0;
  bit          apb_busy = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    if (b >= CH_UP_A && b <= CH_UP_F) return 4'(b - CH_UP_A + 8'd10);
    if (b >= CH_LO_A && b <= CH_LO_F) return 4'(b - CH_LO_A + 8'd10);
    if (b >= CH_ZERO && b <= CH_NINE) return 4'(b - CH_ZERO);
    return 4'd0;
  endfunction

  function automatic logic [11:0] note_hz(input logic [3:0] n);
    case (n)
      4'd1: return 12'd262;
      4'd2: return 12'd294;
      4'd3: return 12'd330;
      4'd4: return 12'd349;
      4'd5: return 12'd392;
      4'd6: return 12'd440;
      4'd7: return 12'd494;
      4'd8: return 12'd523;
      4'd9: return 12'd587;
      default: return 12'd0;
    endcase
  endfunction

  // Advance the tracked state by one byte; returns 1 when the byte completes a result
  function automatic bit decode_command_byte(input logic [7:0] b,
                                             output shcd_pkg::shcd_res_t r);
    logic [3:0]  n;
    logic [1:0]  need;
    logic [11:0] freq;
    logic [23:0] quot;
    logic [23:0] top;
    r = '0;
    if (cmd_phase == PH_IDLE) begin
      case (b)
        shcd_pkg::CmdPort:   cmd_phase = PH_PORT;
        shcd_pkg::CmdDigit:  cmd_phase = PH_DIGIT;
        shcd_pkg::CmdSegClr: cmd_phase = PH_SEG_CLR;
        shcd_pkg::CmdSegSet: cmd_phase = PH_SEG_SET;
        shcd_pkg::CmdPeriod: cmd_phase = PH_PERIOD;
        shcd_pkg::CmdNote:   cmd_phase = PH_NOTE;
        shcd_pkg::CmdMelody: cmd_phase = PH_MELODY;
        default: begin
          r.reply = shcd_pkg::ReplyQuery;
          return 1'b1;
        end
      endcase
      digit_cnt = '0;
      arg_acc   = '0;
      return 1'b0;
    end
    if (cmd_phase == PH_MELODY) begin
      r.reply          = shcd_pkg::ReplyBar;
      r.melody_request = (b == shcd_pkg::MelodyOn);
      cmd_phase = PH_IDLE;
      digit_cnt = '0;
      arg_acc   = '0;
      return 1'b1;
    end
    // Shift in one digit; hold until the command has all of its digits
    arg_acc   = {arg_acc[7:0], hex_digit(b)};
    digit_cnt = digit_cnt + 2'd1;
    need = (cmd_phase == PH_PORT) ? 2'd2 : (cmd_phase == PH_PERIOD) ? 2'd3 : 2'd1;
    if (digit_cnt < need) return 1'b0;
    n    = arg_acc[3:0];
    freq = '0;
    case (cmd_phase)
      PH_PORT: begin
        r.reply      = shcd_pkg::ReplyDot;
        r.port_write = 1'b1;
        r.port_value = arg_acc[7:0];
      end
      PH_DIGIT: begin
        seg_pat = DIGIT_SEGS[n];
        r.reply = shcd_pkg::ReplyBang;
      end
      PH_SEG_CLR: begin
        if (n >= 4'd1 && n <= 4'd8) seg_pat[n - 4'd1] = 1'b0;
        r.reply = shcd_pkg::ReplyBang;
      end
      PH_SEG_SET: begin
        if (n >= 4'd1 && n <= 4'd8) seg_pat[n - 4'd1] = 1'b1;
        r.reply = shcd_pkg::ReplyBar;
      end
      PH_PERIOD: begin
        freq    = arg_acc;
        r.reply = shcd_pkg::ReplyBar;
      end
      default: begin
        freq    = note_hz(n);
        r.reply = shcd_pkg::ReplyBar;
      end
    endcase
    if (cmd_phase inside {PH_DIGIT, PH_SEG_CLR, PH_SEG_SET}) begin
      r.display_write = 1'b1;
      r.display_bits  = ~seg_pat;
    end
    if (cmd_phase inside {PH_PERIOD, PH_NOTE}) begin
      r.tone_write = 1'b1;
      if (freq != '0) begin
        quot = tone_base_q / {12'd0, freq};
        top  = (quot == '0) ? '0 : quot - 24'd1;
        if (top > 24'd65535) top = 24'd65535;
        r.tone_enable  = 1'b1;
        r.tone_top     = top[15:0];
        r.tone_compare = top[15:1];
      end
    end
    cmd_phase = PH_IDLE;
    digit_cnt = '0;
    arg_acc   = '0;
    return 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int unsigned draw_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return CH_ZERO + {4'h0, v};
    return (lower ? CH_LO_A : CH_UP_A) + {4'h0, v} - 8'd10;
  endfunction

  // Argument byte: usually a hex digit up to max, sometimes any byte at all
  function automatic logic [7:0] rand_arg(input int unsigned max);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return hex_char(4'($urandom_range(0, max)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input bit hold = 1'b0);
    byte_q.push_back('{b: b, hold: hold});
    bytes_queued++;
  endtask

  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    apb_busy = 1'b1;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    apb_busy = 1'b0;
  endtask

  task automatic set_tone_base(input logic [23:0] v);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_TONE_BASE, {8'h00, v}, rd);
    tone_base_q = v;
    apb_access(1'b0, ADDR_TONE_BASE, 32'h0, rd);
    check_field("tone_base", {8'h00, v}, rd);
  endtask

  // Queue random commands, mostly well formed, until budget more bytes are queued
  task automatic queue_random_commands(input int unsigned budget);
    int unsigned stop_at;
    bit          hold;
    stop_at = bytes_queued + budget;
    hold    = 1'b1;
    while (bytes_queued < stop_at) begin
      if ($urandom_range(0, 99) < 12) begin
        push_byte(8'($urandom_range(0, 255)), hold);
      end else begin
        case ($urandom_range(0, 6))
          0: begin
            push_byte(shcd_pkg::CmdPort, hold);
            push_byte(rand_arg(15));
            push_byte(rand_arg(15));
          end
          1: begin
            push_byte(shcd_pkg::CmdDigit, hold);
            push_byte(rand_arg(15));
          end
          2: begin
            push_byte(shcd_pkg::CmdSegClr, hold);
            push_byte(rand_arg(9));
          end
          3: begin
            push_byte(shcd_pkg::CmdSegSet, hold);
            push_byte(rand_arg(9));
          end
          4: begin
            push_byte(shcd_pkg::CmdPeriod, hold);
            if ($urandom_range(0, 99) < 30) begin
              push_byte(CH_ZERO);
              push_byte(CH_ZERO);
            end else begin
              push_byte(rand_arg(15));
              push_byte(rand_arg(15));
            end
            push_byte(rand_arg(15));
          end
          5: begin
            push_byte(shcd_pkg::CmdNote, hold);
            push_byte(rand_arg(15));
          end
          default: begin
            push_byte(shcd_pkg::CmdMelody, hold);
            push_byte(($urandom_range(0, 1) == 1) ? shcd_pkg::MelodyOn
                                                  : 8'($urandom_range(0, 255)));
          end
        endcase
      end
      hold = ($urandom_range(0, 99) < 2);
    end
  endtask

  // Wait for every beat to drain, close any open command, then let the block go quiet
  task automatic settle();
    bit busy;
    busy = 1'b1;
    while (busy) begin
      while (byte_q.size() > 0 || rx_bus.valid) @(posedge clk_i);
      while (command_results_q.size() > 0) @(posedge clk_i);
      if (cmd_phase == PH_IDLE) busy = 1'b0;
      else push_byte(CH_ZERO);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Drive rx beats from the pending queue
  always @(negedge clk_i) begin
    rx_item_t   item;
    logic       nv;
    logic [7:0] nb;
    if (rst_ni && (!rx_bus.valid || rx_taken)) begin
      nv = 1'b0;
      nb = rx_bus.rx_byte;
      if (rx_gap > 0) begin
        rx_gap--;
      end else if (byte_q.size() > 0 &&
                   !(byte_q[0].hold && command_results_q.size() > 0)) begin
        item   = byte_q.pop_front();
        nv     = 1'b1;
        nb     = item.b;
        rx_gap = draw_gap(rx_quiet);
      end
      rx_bus.valid   <= nv;
      rx_bus.rx_byte <= nb;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_stall > 0) begin
        res_stall--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) res_stall = draw_gap(res_quiet);
      end
    end
  end

  // Predict on every accepted byte, check every accepted result beat
  always @(posedge clk_i) begin
    shcd_pkg::shcd_res_t want;
    rx_taken = rx_bus.valid && rx_bus.ready;
    if (rst_ni && rx_taken) begin
      if (decode_command_byte(rx_bus.rx_byte, want)) command_results_q.push_back(want);
    end
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (command_results_q.size() == 0) begin
        $error("result beat with no command pending: reply %0h", res_bus.reply);
        mismatches++;
      end else begin
        want = command_results_q.pop_front();
        check_field("reply", want.reply, res_bus.reply);
        check_field("port_write", want.port_write, res_bus.port_write);
        check_field("port_value", want.port_value, res_bus.port_value);
        check_field("display_write", want.display_write, res_bus.display_write);
        check_field("display_bits", want.display_bits, res_bus.display_bits);
        check_field("tone_write", want.tone_write, res_bus.tone_write);
        check_field("tone_enable", want.tone_enable, res_bus.tone_enable);
        check_field("tone_top", want.tone_top, res_bus.tone_top);
        check_field("tone_compare", want.tone_compare, res_bus.tone_compare);
        check_field("melody_request", want.melody_request, res_bus.melody_request);
      end
    end
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || apb_busy || (rx_bus.valid && rx_bus.ready) ||
        (res_bus.valid && res_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL serial_hex_command_decoder_core");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    logic [23:0] bases [6];
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    res_bus.ready  = 1'b0;
    bases[0] = 24'd16000000;
    bases[1] = 24'd1;
    bases[2] = 24'd500;
    bases[3] = 24'($urandom_range(1, 16000000));
    bases[4] = 24'($urandom_range(1, 4095));
    bases[5] = TONE_BASE_RST;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset value, and a write to an unmapped address that must change nothing
    apb_access(1'b0, ADDR_TONE_BASE, 32'h0, rd);
    check_field("tone_base", {8'h00, TONE_BASE_RST}, rd);
    apb_access(1'b1, ADDR_SPARE, 32'h0000_0001, rd);

    // Directed: field extremes, every command, out-of-range indexes, silence, unknown letter
    push_byte(shcd_pkg::CmdPort, 1'b1);
    push_byte(CH_UP_F);
    push_byte(CH_LO_F);
    push_byte(shcd_pkg::CmdDigit);
    push_byte(CH_ZERO + 8'd8);
    push_byte(shcd_pkg::CmdSegClr);
    push_byte(CH_ZERO + 8'd1);
    push_byte(shcd_pkg::CmdSegSet);
    push_byte(CH_ZERO + 8'd8);
    push_byte(shcd_pkg::CmdSegClr);
    push_byte(CH_NONHEX);
    push_byte(shcd_pkg::CmdSegSet);
    push_byte(CH_NINE);
    push_byte(shcd_pkg::CmdPeriod);
    push_byte(CH_UP_F);
    push_byte(CH_UP_F);
    push_byte(CH_UP_F);
    push_byte(shcd_pkg::CmdNote);
    push_byte(CH_ZERO);
    push_byte(shcd_pkg::CmdNote);
    push_byte(CH_NINE);
    push_byte(shcd_pkg::CmdNote);
    push_byte(CH_LO_A);
    push_byte(shcd_pkg::CmdMelody);
    push_byte(shcd_pkg::MelodyOn);
    push_byte(CMD_LOWER);
    queue_random_commands(250);
    settle();

    // Random traffic under each tone base setting
    foreach (bases[i]) begin
      set_tone_base(bases[i]);
      queue_random_commands(280);
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS serial_hex_command_decoder_core");
    end else begin
      $display("FAIL serial_hex_command_decoder_core");
    end
    $finish;
  end

endmodule
